// ===== sv/htt_pkg.sv =====
// types, constants and codes shared by the history heuristic table
`timescale 1ns / 1ps
package htt_pkg;

  localparam int unsigned PIECE_CODES = 16;
  localparam int unsigned SQUARES     = 64;
  localparam int unsigned ENTRIES     = PIECE_CODES * SQUARES;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);
  localparam int unsigned CNT_W       = $clog2(ENTRIES + 1);
  localparam int unsigned PIECE_W     = 4;
  localparam int unsigned SQUARE_W    = 6;
  localparam int unsigned DEPTH_W     = 7;
  localparam int unsigned ADD_W       = 2 * DEPTH_W;
  localparam int unsigned SCORE_W     = 31;
  localparam int unsigned THR_W       = 30;
  localparam int unsigned AGE_SHIFT   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SCORE_W-1:0] ENTRY_MAX  = {SCORE_W{1'b1}};
  localparam logic [THR_W-1:0]   THR_RESET  = THR_W'(32000);

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_BUMP   = 2'd1;
  localparam logic [1:0] MODE_DECAY  = 2'd2;
  localparam logic [1:0] MODE_LOOKUP = 2'd3;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_BUMP,
    OP_DECAY,
    OP_LOOKUP,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [PIECE_W-1:0]  piece;
    logic [SQUARE_W-1:0] to_square;
    logic [DEPTH_W-1:0]  remaining_depth;
    logic                is_capture;
    logic                is_promotion;
    logic                is_interrupt;
  } item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] history_score;
    logic               found;
    logic               aged;
  } result_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic             skip;
    logic [ADD_W-1:0] add;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

// ===== sv/htt_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module htt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/htt_front.sv =====
// front end: accepts items and classifies them into table commands
`timescale 1ns / 1ps
module htt_front (
  input  logic          start,
  input  logic          busy,
  input  htt_pkg::item_t item,
  output logic          push,
  output htt_pkg::cmd_t cmd
);
  import htt_pkg::*;

  logic in_range;

  assign push     = start && !busy;
  assign in_range = (32'(item.piece) < PIECE_CODES) && (32'(item.to_square) < SQUARES);

  always_comb begin
    cmd.idx  = IDX_W'(IDX_W'(item.piece) * IDX_W'(SQUARES) + IDX_W'(item.to_square));
    cmd.skip = item.is_capture || item.is_promotion || item.is_interrupt;
    cmd.add  = ADD_W'(item.remaining_depth) * ADD_W'(item.remaining_depth);
    unique case (item.mode)
      MODE_CLEAR:  cmd.op = OP_CLEAR;
      MODE_BUMP:   cmd.op = in_range ? OP_BUMP : OP_NONE;
      MODE_DECAY:  cmd.op = in_range ? OP_DECAY : OP_NONE;
      MODE_LOOKUP: cmd.op = in_range ? OP_LOOKUP : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== sv/htt_queue.sv =====
// short command queue between front and back
`timescale 1ns / 1ps
module htt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  htt_pkg::cmd_t     din,
  input  logic              pop,
  output htt_pkg::cmd_t     dout,
  output htt_pkg::q_status_t status
);
  import htt_pkg::*;

  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign dout         = slots[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

endmodule

// ===== sv/htt_back.sv =====
// back end: table read-modify-write, clear and aging sweeps
`timescale 1ns / 1ps
module htt_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [htt_pkg::THR_W-1:0] threshold,
  input  htt_pkg::cmd_t          head,
  input  htt_pkg::q_status_t     q_status,
  output logic                   pop,
  output htt_pkg::back_status_t  status,
  output logic                   done,
  output htt_pkg::result_t       result
);
  import htt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_AGE   = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  state_t             state, state_next;
  cmd_t               cur, cur_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               pv, pv_next;
  logic [IDX_W-1:0]   pa, pa_next;
  logic               clr_report, clr_report_next;
  logic [SCORE_W-1:0] age_score, age_score_next;
  logic               done_next;
  result_t            result_next;
  logic               byp_vld;
  logic [IDX_W-1:0]   byp_addr;
  logic [SCORE_W-1:0] byp_data;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [SCORE_W-1:0] wdata;
  logic [IDX_W-1:0]   raddr;
  logic [SCORE_W-1:0] rdata;

  logic [SCORE_W-1:0] v;
  logic [SCORE_W:0]   sum;
  logic [SCORE_W-1:0] bumped;
  logic               trig;
  logic               dispatch;

  htt_ram #(.WIDTH(SCORE_W), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign status.init_busy = (state == S_CLEAR) && !clr_report;

  // entry value with forwarding of a write made in the read cycle
  assign v      = (byp_vld && byp_addr == cur.idx) ? byp_data : rdata;
  assign sum    = {1'b0, v} + (SCORE_W + 1)'(cur.add);
  assign bumped = sum[SCORE_W] ? ENTRY_MAX : sum[SCORE_W-1:0];
  assign trig   = bumped >= SCORE_W'(threshold);

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    cnt_next        = cnt;
    pv_next         = 1'b0;
    pa_next         = cnt[IDX_W-1:0];
    clr_report_next = clr_report;
    age_score_next  = age_score;
    done_next       = 1'b0;
    result_next     = result;
    pop             = 1'b0;
    we              = 1'b0;
    waddr           = cur.idx;
    wdata           = '0;
    raddr           = head.idx;
    dispatch        = 1'b0;

    unique case (state)
      S_IDLE: begin
        dispatch = 1'b1;
      end
      S_EXEC: begin
        result_next = '{history_score: v, found: 1'b0, aged: 1'b0};
        done_next   = 1'b1;
        dispatch    = 1'b1;
        case (cur.op)
          OP_BUMP: begin
            if (!cur.skip) begin
              we    = 1'b1;
              wdata = bumped;
              result_next.history_score = bumped;
              if (trig) begin
                state_next     = S_AGE;
                cnt_next       = '0;
                age_score_next = bumped >> AGE_SHIFT;
                done_next      = 1'b0;
                dispatch       = 1'b0;
              end
            end
          end
          OP_DECAY: begin
            if (!cur.skip && v != '0) begin
              we    = 1'b1;
              wdata = SCORE_W'(v - 1'b1);
              result_next.history_score = SCORE_W'(v - 1'b1);
            end
          end
          OP_LOOKUP: begin
            result_next.found = (v != '0);
          end
          default: begin
            result_next = '0;
          end
        endcase
      end
      S_AGE: begin
        if (cnt != CNT_W'(ENTRIES)) begin
          raddr    = cnt[IDX_W-1:0];
          cnt_next = CNT_W'(cnt + 1'b1);
          pv_next  = 1'b1;
        end
        we    = pv;
        waddr = pa;
        wdata = rdata >> AGE_SHIFT;
        if (cnt == CNT_W'(ENTRIES) && !pv) begin
          state_next  = S_IDLE;
          done_next   = 1'b1;
          result_next = '{history_score: age_score, found: 1'b0, aged: 1'b1};
        end
      end
      S_CLEAR: begin
        we       = 1'b1;
        waddr    = cnt[IDX_W-1:0];
        wdata    = '0;
        cnt_next = CNT_W'(cnt + 1'b1);
        if (cnt[IDX_W-1:0] == IDX_W'(ENTRIES - 1)) begin
          state_next      = S_IDLE;
          done_next       = clr_report;
          result_next     = '0;
          clr_report_next = 1'b0;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (dispatch) begin
      if (!q_status.empty) begin
        pop      = 1'b1;
        cur_next = head;
        raddr    = head.idx;
        if (head.op == OP_CLEAR) begin
          state_next      = S_CLEAR;
          cnt_next        = '0;
          clr_report_next = 1'b1;
        end else begin
          state_next = S_EXEC;
        end
      end else begin
        state_next = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    pa        <= pa_next;
    age_score <= age_score_next;
    result    <= result_next;
    byp_addr  <= waddr;
    byp_data  <= wdata;
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      pv         <= 1'b0;
      clr_report <= 1'b0;
      done       <= 1'b0;
      byp_vld    <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      pv         <= pv_next;
      clr_report <= clr_report_next;
      done       <= done_next;
      byp_vld    <= we;
    end
  end

endmodule

// ===== sv/history_heuristic_table.sv =====
// top level of the history heuristic table
// bump, decay and lookup: queued, then read-modify-write with write forwarding
// throughput: one bump, decay or lookup per cycle while no clear or aging sweep runs
// clear: one entry per cycle across all 1024 entries, result at its end; aging sweeps them all
// reset: threshold returns to 32000 and a pass clearing all 1024 entries runs with busy high
// results cannot be stalled by the receiver
`timescale 1ns / 1ps
module history_heuristic_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  htt_pkg::item_t            item,
  output logic                      done,
  output htt_pkg::result_t          result,
  input  logic                      cfg_wr_en,
  input  logic [htt_pkg::THR_W-1:0] cfg_wr_data
);
  import htt_pkg::*;

  logic         [THR_W-1:0] threshold;
  logic         q_push;
  logic         q_pop;
  cmd_t         front_cmd;
  cmd_t         q_head;
  q_status_t    q_stat;
  back_status_t back_stat;

  assign busy = q_stat.full || back_stat.init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  htt_front u_front (
    .start (start),
    .busy  (busy),
    .item  (item),
    .push  (q_push),
    .cmd   (front_cmd)
  );

  htt_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .din    (front_cmd),
    .pop    (q_pop),
    .dout   (q_head),
    .status (q_stat)
  );

  htt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .threshold (threshold),
    .head      (q_head),
    .q_status  (q_stat),
    .pop       (q_pop),
    .status    (back_stat),
    .done      (done),
    .result    (result)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_quiet_init: assert property (@(posedge clk) disable iff (rst)
    back_stat.init_busy |=> !done)
    else $error("result during reset clearing pass");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && result.found |-> result.history_score != '0 && !result.aged)
    else $error("found flag with zero score or aged");

endmodule

// ===== tb/history_heuristic_table_check.sv =====
// checker for the history heuristic table: predicts each result and compares
`timescale 1ns / 1ps
module history_heuristic_table_check (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  htt_pkg::item_t            item,
  input  logic                      done,
  input  htt_pkg::result_t          result,
  input  logic                      cfg_wr_en,
  input  logic [htt_pkg::THR_W-1:0] cfg_wr_data,
  output int                        outstanding,
  output int                        failures
);
  import htt_pkg::*;

  logic [31:0]      cutoff_counts [ENTRIES];
  logic [THR_W-1:0] aging_threshold;
  result_t          pending_scores [$];
  result_t          want;
  int               errs;

  function automatic result_t score_transfer(input item_t it);
    result_t          r;
    logic [31:0]      add;
    logic [31:0]      v;
    logic             skip;
    logic [IDX_W-1:0] idx;
    r = '0;
    skip = it.is_capture | it.is_promotion | it.is_interrupt;
    if (it.mode == MODE_CLEAR) begin
      foreach (cutoff_counts[k]) cutoff_counts[k] = '0;
    end else if (it.piece < PIECE_CODES && it.to_square < SQUARES) begin
      idx = IDX_W'(32'(it.piece) * SQUARES + 32'(it.to_square));
      v = cutoff_counts[idx];
      case (it.mode)
        MODE_BUMP: begin
          if (!skip) begin
            add = 32'(it.remaining_depth) * 32'(it.remaining_depth);
            v = (v > {1'b0, ENTRY_MAX} - add) ? {1'b0, ENTRY_MAX} : v + add;
            cutoff_counts[idx] = v;
            if (v >= {2'b00, aging_threshold}) begin
              foreach (cutoff_counts[k]) cutoff_counts[k] = cutoff_counts[k] >> AGE_SHIFT;
              r.aged = 1'b1;
            end
          end
        end
        MODE_DECAY: begin
          if (!skip && v != 0) cutoff_counts[idx] = v - 1;
        end
        default: begin
          r.found = (v != 0);
        end
      endcase
      r.history_score = cutoff_counts[idx][SCORE_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    errs = 0;
    if (rst) begin
      foreach (cutoff_counts[k]) cutoff_counts[k] = '0;
      aging_threshold = THR_RESET;
      pending_scores.delete();
    end else begin
      if (cfg_wr_en) aging_threshold = cfg_wr_data;
      if (start && !busy) pending_scores.push_back(score_transfer(item));
      if (done) begin
        if (pending_scores.size() == 0) begin
          $error("result with no transfer pending: history_score %0d found %0d aged %0d",
                 result.history_score, result.found, result.aged);
          errs++;
        end else begin
          want = pending_scores.pop_front();
          if (result.history_score !== want.history_score) begin
            $error("history_score expected %0d got %0d", want.history_score,
                   result.history_score);
            errs++;
          end
          if (result.found !== want.found) begin
            $error("found expected %0d got %0d", want.found, result.found);
            errs++;
          end
          if (result.aged !== want.aged) begin
            $error("aged expected %0d got %0d", want.aged, result.aged);
            errs++;
          end
        end
      end
    end
    outstanding <= pending_scores.size();
    failures    <= failures + errs;
  end

endmodule

// ===== tb/history_heuristic_table_test.sv =====
// testbench top: drives the history heuristic table and reports the verdict
`timescale 1ns / 1ps
module history_heuristic_table_test;
  import htt_pkg::*;

  localparam int CYCLE_LIMIT = 8_000_000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  item_t            item = '0;
  logic             done;
  result_t          result;
  logic             cfg_wr_en = 1'b0;
  logic [THR_W-1:0] cfg_wr_data = '0;
  int               outstanding;
  int               failures;
  int               cycle_count = 0;
  logic [IDX_W-1:0] hot_entries [8];

  history_heuristic_table dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .done        (done),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  history_heuristic_table_check checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .done        (done),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .outstanding (outstanding),
    .failures    (failures)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic item_t make_move(input logic [1:0] mode, input int piece, input int sq,
                                      input int depth, input bit cap, input bit promo,
                                      input bit intr);
    item_t it;
    it.mode            = mode;
    it.piece           = PIECE_W'(piece);
    it.to_square       = SQUARE_W'(sq);
    it.remaining_depth = DEPTH_W'(depth);
    it.is_capture      = cap;
    it.is_promotion    = promo;
    it.is_interrupt    = intr;
    return it;
  endfunction

  function automatic item_t random_move();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) it.mode = MODE_CLEAR;
    else if (pick < 45) it.mode = MODE_BUMP;
    else if (pick < 65) it.mode = MODE_DECAY;
    else it.mode = MODE_LOOKUP;
    // mostly a few hot entries so counts climb and the sweep fires
    if ($urandom_range(99) < 80) begin
      {it.piece, it.to_square} = hot_entries[3'($urandom_range(7))];
    end else begin
      it.piece     = PIECE_W'($urandom_range(15));
      it.to_square = SQUARE_W'($urandom_range(63));
    end
    it.remaining_depth = DEPTH_W'($urandom_range(127));
    it.is_capture      = ($urandom_range(99) < 8);
    it.is_promotion    = ($urandom_range(99) < 8);
    it.is_interrupt    = ($urandom_range(99) < 8);
    return it;
  endfunction

  task automatic send(input item_t it, input int idle_pct);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_random(input int count, input int idle_pct);
    repeat (count) send(random_move(), idle_pct);
  endtask

  initial begin
    hot_entries[0] = '0;
    hot_entries[1] = '1;
    for (int k = 2; k < 8; k++) hot_entries[k] = IDX_W'($urandom_range(ENTRIES - 1));
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (rst);

    send(make_move(MODE_LOOKUP, 0, 0, 0, 0, 0, 0), 26);
    send(make_move(MODE_LOOKUP, 15, 63, 127, 1, 1, 1), 26);
    send(make_move(MODE_BUMP, 15, 63, 127, 0, 0, 0), 26);
    send(make_move(MODE_LOOKUP, 15, 63, 0, 0, 0, 0), 26);
    send(make_move(MODE_BUMP, 15, 63, 0, 0, 0, 0), 26);
    send(make_move(MODE_BUMP, 15, 63, 127, 1, 0, 0), 26);
    send(make_move(MODE_BUMP, 15, 63, 127, 0, 1, 0), 26);
    send(make_move(MODE_BUMP, 15, 63, 127, 0, 0, 1), 26);
    send(make_move(MODE_DECAY, 15, 63, 0, 0, 0, 0), 26);
    send(make_move(MODE_DECAY, 0, 0, 0, 0, 0, 0), 26);
    send(make_move(MODE_DECAY, 15, 63, 0, 1, 1, 1), 26);
    send(make_move(MODE_BUMP, 0, 0, 127, 0, 0, 0), 26);
    send(make_move(MODE_BUMP, 15, 63, 127, 0, 0, 0), 26);
    send(make_move(MODE_LOOKUP, 0, 0, 0, 0, 0, 0), 26);
    send(make_move(MODE_CLEAR, 9, 17, 33, 0, 0, 0), 26);
    send(make_move(MODE_LOOKUP, 15, 63, 0, 0, 0, 0), 26);

    // zero threshold: any bump that is not skipped sweeps
    set_threshold('0);
    send(make_move(MODE_BUMP, 3, 5, 0, 0, 0, 0), 26);
    send(make_move(MODE_LOOKUP, 3, 5, 0, 0, 0, 0), 26);
    set_threshold('1);
    send(make_move(MODE_BUMP, 7, 42, 100, 0, 0, 0), 26);
    send(make_move(MODE_LOOKUP, 7, 42, 0, 0, 0, 0), 26);
    set_threshold(THR_W'(1));
    send(make_move(MODE_BUMP, 7, 42, 1, 0, 0, 0), 26);
    send(make_move(MODE_LOOKUP, 7, 42, 0, 0, 0, 0), 26);

    set_threshold(THR_RESET);
    run_random(500, 26);
    set_threshold('1);
    run_random(500, 79);
    set_threshold(THR_W'($urandom_range(100000, 1000)));
    run_random(450, 0);
    set_threshold(THR_W'(1));
    run_random(50, 0);

    drain();
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
